// ----- rtl/core/bmz_pkg.sv -----
// ----------------------------------------------------------------------------
// bmz_pkg: shared types and constants of the bilinear mesh height lookup
// Field widths, fixed-point formats, register map and the item structs.
// ----------------------------------------------------------------------------
package bmz_pkg;

  // field widths
  localparam int COORD_W  = 20;   // positions and origins, 1/256 mm
  localparam int FACTOR_W = 24;   // cells per mm, Q8.16
  localparam int Z_W      = 16;   // heights, micrometres
  localparam int IDX_W    = 4;    // mesh column / row

  // fixed-point formats
  localparam int POS_FRAC    = 8;                     // 1/256 mm
  localparam int FACTOR_FRAC = 16;                    // Q8.16
  localparam int RATIO_FRAC  = POS_FRAC + FACTOR_FRAC; // Q24 cells
  localparam int Q_FRAC      = 16;                    // blend weights, Q16
  localparam int FRAC_W      = 37;                    // signed Q16 fraction

  // mesh geometry defaults
  localparam int MESH_POINTS_X_DEF = 8;
  localparam int MESH_POINTS_Y_DEF = 8;
  localparam int BOX_KEEP_LAST     = 2;   // last box index below the point count
  localparam int EDGE_HOLD         = 1;   // last point index below the point count

  // pipeline
  localparam int AXIS_STAGES  = 3;
  localparam int BLEND_STAGES = 7;

  // configuration port
  localparam int APB_AW         = 5;
  localparam int APB_DW         = 32;
  localparam int FACTOR_RST_VAL = 6554;

  localparam logic signed [Z_W-1:0] Z_MAX = 16'sh7fff;
  localparam logic signed [Z_W-1:0] Z_MIN = 16'sh8000;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    REG_START_X  = 3'd0,
    REG_START_Y  = 3'd1,
    REG_FACTOR_X = 3'd2,
    REG_FACTOR_Y = 3'd3,
    REG_EXTRAP   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    func_t                     func;
    logic [IDX_W-1:0]          index_x;
    logic [IDX_W-1:0]          index_y;
    logic signed [Z_W-1:0]     z_value;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic signed [Z_W-1:0] offset;
    logic [IDX_W-1:0]      cell_x;
    logic [IDX_W-1:0]      cell_y;
    logic                  saturated;
  } out_result_t;

  // write item fields carried to the mesh write stage
  typedef struct packed {
    func_t                 func;
    logic [IDX_W-1:0]      index_x;
    logic [IDX_W-1:0]      index_y;
    logic signed [Z_W-1:0] z_value;
  } wr_info_t;

  // per-item tag carried beside the blend datapath
  typedef struct packed {
    func_t            func;
    logic [IDX_W-1:0] cell_x;
    logic [IDX_W-1:0] cell_y;
  } tag_t;

  // parity of the box corners, picks mesh banks
  typedef struct packed {
    logic cx0;
    logic nx0;
    logic cy0;
    logic ny0;
  } corner_sel_t;

endpackage

// ----- rtl/core/bilinear_mesh_z_offset.sv -----
// ----------------------------------------------------------------------------
// bilinear_mesh_z_offset: bed mesh height lookup with bilinear blend
// Stores mesh heights from write items and returns the blended offset at
// the position of each query item.
// ----------------------------------------------------------------------------
// A result strobe follows each start transfer, for writes and queries
// alike. Throughput: one item per cycle; busy stays low.
// The mesh lives in four parity banks, so all four box corners are read in
// the same cycle. Reset clears the valid pipeline and presets the config
// registers; mesh heights stay undefined until written (no clearing pass).
module bilinear_mesh_z_offset #(
  parameter int MESH_POINTS_X = bmz_pkg::MESH_POINTS_X_DEF,
  parameter int MESH_POINTS_Y = bmz_pkg::MESH_POINTS_Y_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  bmz_pkg::in_item_t           in_item,
  output logic                        out_strobe,
  output bmz_pkg::out_result_t        out_result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bmz_pkg::APB_AW-1:0]  paddr,
  input  logic [bmz_pkg::APB_DW-1:0]  pwdata,
  output logic [bmz_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import bmz_pkg::*;

  localparam int PIPE_STAGES = AXIS_STAGES + 1 + BLEND_STAGES;
  localparam int TAG_DEPTH   = BLEND_STAGES + 1;
  localparam int BANK_COLS   = (MESH_POINTS_X + 1) / 2;
  localparam int BANK_ROWS   = (MESH_POINTS_Y + 1) / 2;
  localparam int BANK_DEPTH  = BANK_COLS * BANK_ROWS;
  localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // configuration registers
  logic signed [COORD_W-1:0] start_x_r, start_y_r;
  logic [FACTOR_W-1:0]       factor_x_r, factor_y_r;
  logic                      extrap_r;
  logic                      cfg_wr;
  reg_idx_t                  cfg_idx;

  // pipeline control
  logic                    accept;
  logic [PIPE_STAGES-1:0]  vld_r, vld_nxt;
  wr_info_t                wr_r [AXIS_STAGES];
  tag_t                    tag_r [TAG_DEPTH];
  corner_sel_t             sel_r;
  logic signed [FRAC_W-1:0] fx4_r, fy4_r;

  // axis outputs, stage 3
  logic [IDX_W-1:0]         ax_cell, ax_cell_hi, ay_cell, ay_cell_hi;
  logic signed [FRAC_W-1:0] ax_frac, ay_frac;

  // mesh banks
  logic                     mesh_we;
  logic [1:0]               mesh_wbank;
  logic [BANK_AW-1:0]       mesh_waddr;
  logic signed [Z_W-1:0]    rd_r [4];
  logic signed [Z_W-1:0]    z00, z01, z10, z11;

  // blend outputs, stage 11
  logic signed [Z_W-1:0]    blend_offset;
  logic                     blend_sat;

  logic                     out_strobe_r;
  out_result_t              out_result_r, out_result_nxt;

  function automatic logic [BANK_AW-1:0] bank_addr(input logic [IDX_W-1:0] col,
                                                   input logic [IDX_W-1:0] row);
    return BANK_AW'(int'(row >> 1) * BANK_COLS + int'(col >> 1));
  endfunction

  function automatic logic signed [Z_W-1:0] pick(input logic [1:0] bank,
                                                 input logic signed [Z_W-1:0] d0,
                                                 input logic signed [Z_W-1:0] d1,
                                                 input logic signed [Z_W-1:0] d2,
                                                 input logic signed [Z_W-1:0] d3);
    logic signed [Z_W-1:0] res;
    case (bank)
      2'd0:    res = d0;
      2'd1:    res = d1;
      2'd2:    res = d2;
      default: res = d3;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r  <= '0;
      start_y_r  <= '0;
      factor_x_r <= FACTOR_W'(FACTOR_RST_VAL);
      factor_y_r <= FACTOR_W'(FACTOR_RST_VAL);
      extrap_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_START_X:  start_x_r  <= pwdata[COORD_W-1:0];
        REG_START_Y:  start_y_r  <= pwdata[COORD_W-1:0];
        REG_FACTOR_X: factor_x_r <= pwdata[FACTOR_W-1:0];
        REG_FACTOR_Y: factor_y_r <= pwdata[FACTOR_W-1:0];
        REG_EXTRAP:   extrap_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_START_X:  prdata = APB_DW'(unsigned'(start_x_r));
      REG_START_Y:  prdata = APB_DW'(unsigned'(start_y_r));
      REG_FACTOR_X: prdata = APB_DW'(factor_x_r);
      REG_FACTOR_Y: prdata = APB_DW'(factor_y_r);
      REG_EXTRAP:   prdata = APB_DW'(extrap_r);
      default:      prdata = '0;
    endcase
  end

  // -------------------------------------------------------------- pipeline
  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign vld_nxt = {vld_r[PIPE_STAGES-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      vld_r        <= vld_nxt;
      out_strobe_r <= vld_r[PIPE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    wr_r[0] <= '{func: in_item.func, index_x: in_item.index_x,
                 index_y: in_item.index_y, z_value: in_item.z_value};
    for (int i = 1; i < AXIS_STAGES; i++) begin
      wr_r[i] <= wr_r[i-1];
    end
    tag_r[0] <= '{func: wr_r[AXIS_STAGES-1].func, cell_x: ax_cell, cell_y: ay_cell};
    for (int i = 1; i < TAG_DEPTH; i++) begin
      tag_r[i] <= tag_r[i-1];
    end
    sel_r <= '{cx0: ax_cell[0], nx0: ax_cell_hi[0], cy0: ay_cell[0], ny0: ay_cell_hi[0]};
    fx4_r <= ax_frac;
    fy4_r <= ay_frac;
  end

  bmz_axis #(.POINTS(MESH_POINTS_X)) u_axis_x (
    .clk       (clk),
    .pos_i     (in_item.pos_x),
    .start_i   (start_x_r),
    .factor_i  (factor_x_r),
    .extrap_i  (extrap_r),
    .cell_o    (ax_cell),
    .cell_hi_o (ax_cell_hi),
    .frac_o    (ax_frac)
  );

  bmz_axis #(.POINTS(MESH_POINTS_Y)) u_axis_y (
    .clk       (clk),
    .pos_i     (in_item.pos_y),
    .start_i   (start_y_r),
    .factor_i  (factor_y_r),
    .extrap_i  (extrap_r),
    .cell_o    (ay_cell),
    .cell_hi_o (ay_cell_hi),
    .frac_o    (ay_frac)
  );

  // ------------------------------------------------------------ mesh banks
  // writes and reads share stage 3, so items see the mesh in order
  always_comb begin
    mesh_we = vld_r[AXIS_STAGES-1] && (wr_r[AXIS_STAGES-1].func == FUNC_WRITE)
           && ({1'b0, wr_r[AXIS_STAGES-1].index_x} < (IDX_W+1)'(MESH_POINTS_X))
           && ({1'b0, wr_r[AXIS_STAGES-1].index_y} < (IDX_W+1)'(MESH_POINTS_Y));
    mesh_wbank = {wr_r[AXIS_STAGES-1].index_y[0], wr_r[AXIS_STAGES-1].index_x[0]};
    mesh_waddr = bank_addr(wr_r[AXIS_STAGES-1].index_x, wr_r[AXIS_STAGES-1].index_y);
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic XP = 1'(b % 2);
    localparam logic YP = 1'(b / 2);

    logic signed [Z_W-1:0] mem [BANK_DEPTH];
    logic [IDX_W-1:0]      col, row;
    logic [BANK_AW-1:0]    rd_addr;

    always_comb begin
      col     = (ax_cell[0] == XP) ? ax_cell : ax_cell_hi;
      row     = (ay_cell[0] == YP) ? ay_cell : ay_cell_hi;
      rd_addr = bank_addr(col, row);
    end

    always_ff @(posedge clk) begin
      if (mesh_we && (mesh_wbank == 2'(b))) begin
        mem[mesh_waddr] <= wr_r[AXIS_STAGES-1].z_value;
      end
      rd_r[b] <= mem[rd_addr];
    end
  end

  always_comb begin
    z00 = pick({sel_r.cy0, sel_r.cx0}, rd_r[0], rd_r[1], rd_r[2], rd_r[3]);
    z01 = pick({sel_r.ny0, sel_r.cx0}, rd_r[0], rd_r[1], rd_r[2], rd_r[3]);
    z10 = pick({sel_r.cy0, sel_r.nx0}, rd_r[0], rd_r[1], rd_r[2], rd_r[3]);
    z11 = pick({sel_r.ny0, sel_r.nx0}, rd_r[0], rd_r[1], rd_r[2], rd_r[3]);
  end

  bmz_blend u_blend (
    .clk      (clk),
    .z00_i    (z00),
    .z01_i    (z01),
    .z10_i    (z10),
    .z11_i    (z11),
    .fx_i     (fx4_r),
    .fy_i     (fy4_r),
    .offset_o (blend_offset),
    .sat_o    (blend_sat)
  );

  // ---------------------------------------------------------------- result
  always_comb begin
    if (tag_r[TAG_DEPTH-1].func == FUNC_QUERY) begin
      out_result_nxt = '{offset: blend_offset, cell_x: tag_r[TAG_DEPTH-1].cell_x,
                         cell_y: tag_r[TAG_DEPTH-1].cell_y, saturated: blend_sat};
    end else begin
      out_result_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

  // ------------------------------------------------------------ assertions
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_result.saturated |->
      (out_result.offset == Z_MAX) || (out_result.offset == Z_MIN))
    else $error("saturated result not at a range limit");

  a_next_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[AXIS_STAGES-1] |->
      ((ax_cell_hi == ax_cell) || (ax_cell_hi == ax_cell + 1'b1)) &&
      ((ay_cell_hi == ay_cell) || (ay_cell_hi == ay_cell + 1'b1)))
    else $error("next grid point not adjacent to box cell");

  a_cell_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |->
      ({1'b0, out_result.cell_x} < (IDX_W+1)'(MESH_POINTS_X)) &&
      ({1'b0, out_result.cell_y} < (IDX_W+1)'(MESH_POINTS_Y)))
    else $error("result cell outside the mesh");

  a_strobe_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(vld_r[0], PIPE_STAGES))
    else $error("result strobe without a matching transfer");

endmodule

// ----- rtl/core/bmz_axis.sv -----
// ----------------------------------------------------------------------------
// bmz_axis: one axis of the position split
// Three stages: origin subtract, scale to Q24 cells, floor and clamp to a box
// with the next grid point and a signed Q16 fraction.
// ----------------------------------------------------------------------------
module bmz_axis #(
  parameter int POINTS = bmz_pkg::MESH_POINTS_X_DEF
) (
  input  logic                              clk,
  input  logic signed [bmz_pkg::COORD_W-1:0] pos_i,
  input  logic signed [bmz_pkg::COORD_W-1:0] start_i,
  input  logic [bmz_pkg::FACTOR_W-1:0]      factor_i,
  input  logic                              extrap_i,
  output logic [bmz_pkg::IDX_W-1:0]         cell_o,
  output logic [bmz_pkg::IDX_W-1:0]         cell_hi_o,
  output logic signed [bmz_pkg::FRAC_W-1:0] frac_o
);
  import bmz_pkg::*;

  localparam int REL_W    = COORD_W + 1;
  localparam int RATIO_W  = REL_W + FACTOR_W + 1;
  localparam int WHOLE_W  = RATIO_W - RATIO_FRAC;
  localparam int PAD_W    = RATIO_W - IDX_W - RATIO_FRAC;
  localparam int DROP     = RATIO_FRAC - Q_FRAC;
  localparam int TOP_EDGE = POINTS - EDGE_HOLD;
  localparam int TOP_BOX  = POINTS - BOX_KEEP_LAST;

  logic signed [REL_W-1:0]   rel_r, rel_nxt;
  logic signed [RATIO_W-1:0] ratio_r, ratio_nxt;
  logic signed [FACTOR_W:0]  factor_s;
  logic signed [WHOLE_W-1:0] whole, top_s;
  logic                      below, above;
  logic [IDX_W-1:0]          cell_cl;
  logic [IDX_W:0]            cell_inc;
  logic signed [RATIO_W-1:0] base, frac_full;
  logic [IDX_W-1:0]          cell_r, cell_nxt, cell_hi_r, cell_hi_nxt;
  logic signed [FRAC_W-1:0]  frac_r, frac_nxt;

  always_comb begin
    rel_nxt   = REL_W'(pos_i) - REL_W'(start_i);
    factor_s  = $signed({1'b0, factor_i});
    ratio_nxt = rel_r * factor_s;
  end

  always_comb begin
    whole   = ratio_r[RATIO_W-1:RATIO_FRAC];
    top_s   = extrap_i ? WHOLE_W'(TOP_BOX) : WHOLE_W'(TOP_EDGE);
    below   = ratio_r[RATIO_W-1];
    above   = whole > top_s;
    if (below) begin
      cell_cl = '0;
    end else if (above) begin
      cell_cl = top_s[IDX_W-1:0];
    end else begin
      cell_cl = whole[IDX_W-1:0];
    end
    base      = $signed({{PAD_W{1'b0}}, cell_cl, {RATIO_FRAC{1'b0}}});
    frac_full = ratio_r - base;
    // hold the edge: outside the grid the fraction is zeroed, so the edge height holds
    if (!extrap_i && (below || above)) begin
      frac_full = '0;
    end
    cell_inc = {1'b0, cell_cl} + 1'b1;
    if (cell_inc < (IDX_W+1)'(POINTS - 1)) begin
      cell_hi_nxt = cell_inc[IDX_W-1:0];
    end else begin
      cell_hi_nxt = IDX_W'(POINTS - 1);
    end
    cell_nxt = cell_cl;
    frac_nxt = frac_full[FRAC_W+DROP-1:DROP];
  end

  always_ff @(posedge clk) begin
    rel_r     <= rel_nxt;
    ratio_r   <= ratio_nxt;
    cell_r    <= cell_nxt;
    cell_hi_r <= cell_hi_nxt;
    frac_r    <= frac_nxt;
  end

  assign cell_o    = cell_r;
  assign cell_hi_o = cell_hi_r;
  assign frac_o    = frac_r;

endmodule

// ----- rtl/core/bmz_blend.sv -----
// ----------------------------------------------------------------------------
// bmz_blend: bilinear blend of four corner heights
// Seven register stages: differences, Y weighting, left/right edges, span,
// X weighting as partial products, partial sums with the rounding half,
// final sum; then saturate to 16 bits.
// ----------------------------------------------------------------------------
module bmz_blend (
  input  logic                               clk,
  input  logic signed [bmz_pkg::Z_W-1:0]     z00_i,
  input  logic signed [bmz_pkg::Z_W-1:0]     z01_i,
  input  logic signed [bmz_pkg::Z_W-1:0]     z10_i,
  input  logic signed [bmz_pkg::Z_W-1:0]     z11_i,
  input  logic signed [bmz_pkg::FRAC_W-1:0]  fx_i,
  input  logic signed [bmz_pkg::FRAC_W-1:0]  fy_i,
  output logic signed [bmz_pkg::Z_W-1:0]     offset_o,
  output logic                               sat_o
);
  import bmz_pkg::*;

  localparam int DL_W     = Z_W + 1;
  localparam int FY_SPLIT = 20;
  localparam int PLO_W    = DL_W + FY_SPLIT + 1;
  localparam int PHI_W    = DL_W + FRAC_W - FY_SPLIT;
  localparam int LQ_W     = 56;
  localparam int DQ_W     = LQ_W + 1;
  localparam int FX_SPLIT = 19;
  localparam int DQ_SPLIT = 28;
  localparam int PLL_W    = FX_SPLIT + 1 + DQ_SPLIT + 1;
  localparam int PLH_W    = FX_SPLIT + 1 + DQ_W - DQ_SPLIT;
  localparam int PHL_W    = FRAC_W - FX_SPLIT + DQ_SPLIT + 1;
  localparam int PHH_W    = FRAC_W - FX_SPLIT + DQ_W - DQ_SPLIT;
  localparam int ACC_W    = 96;
  localparam int OUT_LSB  = 2 * Q_FRAC;

  // stage 1
  logic signed [Z_W-1:0]    z00_1_r, z10_1_r;
  logic signed [DL_W-1:0]   dl_r, dr_r, dl_nxt, dr_nxt;
  logic signed [FRAC_W-1:0] fx1_r, fy1_r;
  // stage 2
  logic signed [FY_SPLIT:0]        fy_lo_s;
  logic signed [FRAC_W-FY_SPLIT-1:0] fy_hi_s;
  logic signed [PLO_W-1:0]  pl_lo_r, pr_lo_r, pl_lo_nxt, pr_lo_nxt;
  logic signed [PHI_W-1:0]  pl_hi_r, pr_hi_r, pl_hi_nxt, pr_hi_nxt;
  logic signed [Z_W-1:0]    z00_2_r, z10_2_r;
  logic signed [FRAC_W-1:0] fx2_r;
  // stage 3
  logic signed [LQ_W-1:0]   lq_r, rq_r, lq_nxt, rq_nxt;
  logic signed [FRAC_W-1:0] fx3_r;
  // stage 4
  logic signed [DQ_W-1:0]   dq_r, dq_nxt;
  logic signed [LQ_W-1:0]   lq4_r;
  logic signed [FRAC_W-1:0] fx4_r;
  // stage 5
  logic signed [FX_SPLIT:0]          fx_lo_s;
  logic signed [FRAC_W-FX_SPLIT-1:0] fx_hi_s;
  logic signed [DQ_SPLIT:0]          dq_lo_s;
  logic signed [DQ_W-DQ_SPLIT-1:0]   dq_hi_s;
  logic signed [PLL_W-1:0]  pp_ll_r, pp_ll_nxt;
  logic signed [PLH_W-1:0]  pp_lh_r, pp_lh_nxt;
  logic signed [PHL_W-1:0]  pp_hl_r, pp_hl_nxt;
  logic signed [PHH_W-1:0]  pp_hh_r, pp_hh_nxt;
  logic signed [LQ_W-1:0]   lq5_r;
  // stages 6 and 7
  logic signed [ACC_W-1:0]  s1_r, s2_r, s1_nxt, s2_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     fits;

  always_comb begin
    dl_nxt = DL_W'(z01_i) - DL_W'(z00_i);
    dr_nxt = DL_W'(z11_i) - DL_W'(z10_i);
  end

  always_comb begin
    fy_lo_s   = $signed({1'b0, fy1_r[FY_SPLIT-1:0]});
    fy_hi_s   = fy1_r[FRAC_W-1:FY_SPLIT];
    pl_lo_nxt = dl_r * fy_lo_s;
    pl_hi_nxt = dl_r * fy_hi_s;
    pr_lo_nxt = dr_r * fy_lo_s;
    pr_hi_nxt = dr_r * fy_hi_s;
  end

  always_comb begin
    lq_nxt = (LQ_W'(z00_2_r) <<< Q_FRAC) + LQ_W'(pl_lo_r) + (LQ_W'(pl_hi_r) <<< FY_SPLIT);
    rq_nxt = (LQ_W'(z10_2_r) <<< Q_FRAC) + LQ_W'(pr_lo_r) + (LQ_W'(pr_hi_r) <<< FY_SPLIT);
    dq_nxt = DQ_W'(rq_r) - DQ_W'(lq_r);
  end

  // split both operands so no product exceeds about 20 by 29 bits
  always_comb begin
    fx_lo_s   = $signed({1'b0, fx4_r[FX_SPLIT-1:0]});
    fx_hi_s   = fx4_r[FRAC_W-1:FX_SPLIT];
    dq_lo_s   = $signed({1'b0, dq_r[DQ_SPLIT-1:0]});
    dq_hi_s   = dq_r[DQ_W-1:DQ_SPLIT];
    pp_ll_nxt = fx_lo_s * dq_lo_s;
    pp_lh_nxt = fx_lo_s * dq_hi_s;
    pp_hl_nxt = fx_hi_s * dq_lo_s;
    pp_hh_nxt = fx_hi_s * dq_hi_s;
  end

  always_comb begin
    s1_nxt = ACC_W'(pp_ll_r) + (ACC_W'(pp_lh_r) <<< DQ_SPLIT)
           + (ACC_W'(pp_hl_r) <<< FX_SPLIT);
    // half an output step rounds the floor upward
    s2_nxt = (ACC_W'(pp_hh_r) <<< (FX_SPLIT + DQ_SPLIT)) + (ACC_W'(lq5_r) <<< Q_FRAC)
           + (ACC_W'(1) <<< (OUT_LSB - 1));
    acc_nxt = s1_r + s2_r;
  end

  always_ff @(posedge clk) begin
    z00_1_r <= z00_i;
    z10_1_r <= z10_i;
    dl_r    <= dl_nxt;
    dr_r    <= dr_nxt;
    fx1_r   <= fx_i;
    fy1_r   <= fy_i;

    pl_lo_r <= pl_lo_nxt;
    pl_hi_r <= pl_hi_nxt;
    pr_lo_r <= pr_lo_nxt;
    pr_hi_r <= pr_hi_nxt;
    z00_2_r <= z00_1_r;
    z10_2_r <= z10_1_r;
    fx2_r   <= fx1_r;

    lq_r    <= lq_nxt;
    rq_r    <= rq_nxt;
    fx3_r   <= fx2_r;

    dq_r    <= dq_nxt;
    lq4_r   <= lq_r;
    fx4_r   <= fx3_r;

    pp_ll_r <= pp_ll_nxt;
    pp_lh_r <= pp_lh_nxt;
    pp_hl_r <= pp_hl_nxt;
    pp_hh_r <= pp_hh_nxt;
    lq5_r   <= lq4_r;

    s1_r    <= s1_nxt;
    s2_r    <= s2_nxt;
    acc_r   <= acc_nxt;
  end

  // the result fits when every bit above the output sign matches it
  always_comb begin
    fits = (acc_r[ACC_W-1:OUT_LSB+Z_W-1] == '0) || (acc_r[ACC_W-1:OUT_LSB+Z_W-1] == '1);
    sat_o = !fits;
    if (fits) begin
      offset_o = acc_r[OUT_LSB+Z_W-1:OUT_LSB];
    end else if (acc_r[ACC_W-1]) begin
      offset_o = Z_MIN;
    end else begin
      offset_o = Z_MAX;
    end
  end

endmodule
